FILE: rtl/core/rpn_stack_evaluator_macros.svh
// ----------------------------------------------------------------------------
// rpn stack evaluator assertion macros
// shared assertion forms for the evaluator
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_EVALUATOR_MACROS_SVH
`define RPN_STACK_EVALUATOR_MACROS_SVH

// implication checked on every edge outside reset
`define RSE_ASSERT_IMP(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("rse assertion failed");

// condition implies expression on the next edge
`define RSE_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("rse assertion failed");

`endif

FILE: rtl/core/rse_pkg.sv
// ----------------------------------------------------------------------------
// rse package
// command codes, queue entry, result and sequencer state types for the rpn evaluator
// ----------------------------------------------------------------------------
`default_nettype none
package rse_pkg;
	localparam logic [2:0] OP_PUSH  = 3'd0;
	localparam logic [2:0] OP_ADD   = 3'd1;
	localparam logic [2:0] OP_SUB   = 3'd2;
	localparam logic [2:0] OP_MUL   = 3'd3;
	localparam logic [2:0] OP_DIV   = 3'd4;
	localparam logic [2:0] OP_PRINT = 3'd5;

	localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] Q_MIN = 32'sh80000000;

	typedef enum logic [1:0] {
		K_PUSH,
		K_BINARY,
		K_PRINT,
		K_UNKNOWN
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  op;
		logic [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic [31:0] printed_value;
		logic        printed_valid;
		logic        empty_error;
		logic        full_error;
		logic        zero_divisor_error;
		logic        unknown_error;
		logic        saturated;
		logic [7:0]  depth_now;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_POP_R,
		S_WAIT_R,
		S_POP_L,
		S_WAIT_L,
		S_ADDSUB,
		S_MUL,
		S_MUL_CLIP,
		S_DIV,
		S_DIV_CLIP,
		S_PUSH,
		S_DONE
	} state_t;
endpackage
`default_nettype wire

FILE: rtl/core/rse_front.sv
// ----------------------------------------------------------------------------
// rse front end
// accepts command beats, classifies them and holds them in a short queue
// ----------------------------------------------------------------------------
`default_nettype none
module rse_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid,
	output logic                 stall,
	input  wire logic [2:0]      op,
	input  wire logic [31:0]     operand_value,
	output logic                 cmd_valid,
	output rse_pkg::cmd_t        cmd,
	input  wire logic            cmd_take
);
	localparam int QD = 4;

	rse_pkg::cmd_t  q_mem_q [QD];
	logic [1:0]     wr_ptr_q;
	logic [1:0]     rd_ptr_q;
	logic [2:0]     cnt_q;
	rse_pkg::cmd_t  new_cmd;
	logic           push;
	logic           pop;

	always_comb begin
		new_cmd.op    = op;
		new_cmd.value = operand_value;
		unique case (op) inside
			rse_pkg::OP_PUSH: new_cmd.kind = rse_pkg::K_PUSH;
			rse_pkg::OP_ADD, rse_pkg::OP_SUB, rse_pkg::OP_MUL, rse_pkg::OP_DIV:
				new_cmd.kind = rse_pkg::K_BINARY;
			rse_pkg::OP_PRINT: new_cmd.kind = rse_pkg::K_PRINT;
			default: new_cmd.kind = rse_pkg::K_UNKNOWN;
		endcase
	end

	assign stall     = (cnt_q == 3'(QD));
	assign push      = valid && !stall;
	assign cmd_valid = (cnt_q != 3'd0);
	assign pop       = cmd_valid && cmd_take;
	assign cmd       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_ptr_q] <= new_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 2'd1;
			if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/rse_back.sv
// ----------------------------------------------------------------------------
// rse back end
// stack memory, sequencer, saturating add, multiply and iterative divide
// ----------------------------------------------------------------------------
`default_nettype none
module rse_back #(
	parameter int STACK_DEPTH = 128
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cmd_valid,
	input  rse_pkg::cmd_t     cmd,
	output logic              cmd_take,
	output logic              res_valid,
	output rse_pkg::res_t     res,
	input  wire logic         res_stall
);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [5:0] DIV_LAST = 6'd48;

	logic [31:0]     mem_q [STACK_DEPTH];
	logic [31:0]     rd_data_q;
	logic [CW-1:0]   cnt_q;
	rse_pkg::state_t state_q, state_d;
	rse_pkg::cmd_t   cur_q;
	logic signed [31:0] r_q, l_q, acc_q;
	logic            e_q, f_q, z_q, sat_q;
	logic [47:0]     prod_q;
	logic            neg_q;
	logic [47:0]     dvd_q;
	logic [47:0]     quo_q;
	logic [31:0]     rem_q;
	logic [31:0]     dvs_q;
	logic [5:0]      step_q;
	logic            out_valid_q;
	rse_pkg::res_t   out_q;

	logic            mem_rd, mem_wr;
	logic [AW-1:0]   rd_addr, wr_addr;
	logic            nonempty;
	logic            done_fire;
	logic signed [31:0] r_pop;
	logic signed [32:0] sum;
	logic [31:0]     mag_l, mag_r;
	logic [63:0]     mag_p;
	logic [32:0]     rem_sh;
	logic [32:0]     rem_sub;
	logic [47:0]     big_mag;
	logic [32:0]     big_s;
	logic signed [31:0] clipped;
	logic            clip_sat;

	assign nonempty  = (cnt_q != '0);
	assign done_fire = (state_q == rse_pkg::S_DONE) && (!out_valid_q || !res_stall);
	assign r_pop     = e_q ? 32'sd0 : rd_data_q;
	assign rd_addr   = AW'(cnt_q - CW'(1));
	assign wr_addr   = AW'(cnt_q);
	assign mag_l     = l_q[31] ? 32'(-l_q) : 32'(l_q);
	assign mag_r     = r_q[31] ? 32'(-r_q) : 32'(r_q);
	assign sum       = (cur_q.op == rse_pkg::OP_SUB) ? (33'(l_q) - 33'(r_q))
		: (33'(l_q) + 33'(r_q));
	assign rem_sh    = {rem_q, dvd_q[47]};
	assign rem_sub   = rem_sh - {1'b0, dvs_q};
	assign big_mag   = (state_q == rse_pkg::S_MUL_CLIP) ? prod_q : quo_q;
	assign big_s     = (big_mag > 48'h100000000) ? 33'h100000000 : 33'(big_mag);

	always_comb begin
		clip_sat = 1'b0;
		clipped  = 32'(big_s);
		if (!neg_q && big_s > 33'h07fffffff) begin
			clipped  = rse_pkg::Q_MAX;
			clip_sat = 1'b1;
		end else if (neg_q) begin
			clipped = 32'(-big_s);
			if (big_s > 33'h080000000) begin
				clipped  = rse_pkg::Q_MIN;
				clip_sat = 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rse_pkg::S_IDLE: if (cmd_valid) begin
				unique case (cmd.kind)
					rse_pkg::K_PUSH:    state_d = rse_pkg::S_PUSH;
					rse_pkg::K_UNKNOWN: state_d = rse_pkg::S_DONE;
					default:            state_d = rse_pkg::S_POP_R;
				endcase
			end
			rse_pkg::S_POP_R:  state_d = rse_pkg::S_WAIT_R;
			rse_pkg::S_WAIT_R: begin
				if (cur_q.kind == rse_pkg::K_PRINT) state_d = rse_pkg::S_DONE;
				else if (cur_q.op == rse_pkg::OP_DIV && r_pop == 32'sd0)
					state_d = rse_pkg::S_DONE;
				else state_d = rse_pkg::S_POP_L;
			end
			rse_pkg::S_POP_L:  state_d = rse_pkg::S_WAIT_L;
			rse_pkg::S_WAIT_L: begin
				unique case (cur_q.op)
					rse_pkg::OP_MUL: state_d = rse_pkg::S_MUL;
					rse_pkg::OP_DIV: state_d = rse_pkg::S_DIV;
					default:         state_d = rse_pkg::S_ADDSUB;
				endcase
			end
			rse_pkg::S_ADDSUB:   state_d = rse_pkg::S_PUSH;
			rse_pkg::S_MUL:      state_d = rse_pkg::S_MUL_CLIP;
			rse_pkg::S_MUL_CLIP: state_d = rse_pkg::S_PUSH;
			rse_pkg::S_DIV: if (step_q == DIV_LAST) state_d = rse_pkg::S_DIV_CLIP;
			rse_pkg::S_DIV_CLIP: state_d = rse_pkg::S_PUSH;
			rse_pkg::S_PUSH:     state_d = rse_pkg::S_DONE;
			rse_pkg::S_DONE: if (done_fire) state_d = rse_pkg::S_IDLE;
			default: state_d = rse_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd_take = 1'b0;
		mem_rd   = 1'b0;
		mem_wr   = 1'b0;
		unique case (state_q) inside
			rse_pkg::S_IDLE:  cmd_take = cmd_valid;
			rse_pkg::S_POP_R, rse_pkg::S_POP_L: mem_rd = nonempty;
			rse_pkg::S_PUSH:  mem_wr = (cnt_q != CW'(STACK_DEPTH));
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_wr) mem_q[wr_addr] <= acc_q;
		if (mem_rd) rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		unique case (state_q) inside
			rse_pkg::S_IDLE: begin
				cur_q <= cmd;
				acc_q <= cmd.value;
			end
			rse_pkg::S_WAIT_R: begin
				r_q <= r_pop;
			end
			rse_pkg::S_WAIT_L: begin
				l_q   <= e_q ? 32'sd0 : rd_data_q;
				neg_q <= (!e_q && rd_data_q[31]) != r_q[31];
			end
			rse_pkg::S_ADDSUB: acc_q <= (sum > 33'sh7fffffff) ? rse_pkg::Q_MAX
				: (sum < -33'sh80000000) ? rse_pkg::Q_MIN : 32'(sum);
			rse_pkg::S_MUL: begin
				prod_q <= 48'(mag_p >> 16);
				dvd_q  <= '0;
			end
			rse_pkg::S_MUL_CLIP, rse_pkg::S_DIV_CLIP: acc_q <= clipped;
			rse_pkg::S_DIV: begin
				if (step_q == 6'd0) begin
					dvd_q <= {mag_l, 16'd0};
					dvs_q <= mag_r;
					rem_q <= '0;
					quo_q <= '0;
				end else begin
					dvd_q <= {dvd_q[46:0], 1'b0};
					if (!rem_sub[32]) begin
						rem_q <= rem_sub[31:0];
						quo_q <= {quo_q[46:0], 1'b1};
					end else begin
						rem_q <= rem_sh[31:0];
						quo_q <= {quo_q[46:0], 1'b0};
					end
				end
			end
			default: ;
		endcase
	end

	assign mag_p = 64'(mag_l) * 64'(mag_r);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rse_pkg::S_IDLE;
			cnt_q       <= '0;
			e_q         <= 1'b0;
			f_q         <= 1'b0;
			z_q         <= 1'b0;
			sat_q       <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= done_fire || (out_valid_q && res_stall);
			unique case (state_q) inside
				rse_pkg::S_IDLE: begin
					e_q <= 1'b0; f_q <= 1'b0; z_q <= 1'b0; sat_q <= 1'b0;
					step_q <= '0;
				end
				rse_pkg::S_POP_R, rse_pkg::S_POP_L: begin
					if (nonempty) cnt_q <= cnt_q - CW'(1);
					else e_q <= 1'b1;
				end
				rse_pkg::S_WAIT_R: if (cur_q.kind == rse_pkg::K_BINARY &&
					cur_q.op == rse_pkg::OP_DIV && r_pop == 32'sd0) z_q <= 1'b1;
				rse_pkg::S_ADDSUB: sat_q <= (sum > 33'sh7fffffff) ||
					(sum < -33'sh80000000);
				rse_pkg::S_MUL_CLIP, rse_pkg::S_DIV_CLIP: sat_q <= clip_sat;
				rse_pkg::S_DIV: step_q <= (step_q == DIV_LAST) ? '0
					: step_q + 6'd1;
				rse_pkg::S_PUSH: begin
					if (cnt_q != CW'(STACK_DEPTH)) cnt_q <= cnt_q + CW'(1);
					else f_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			out_q.printed_value      <= (cur_q.kind == rse_pkg::K_PRINT) ? r_q : '0;
			out_q.printed_valid      <= (cur_q.kind == rse_pkg::K_PRINT);
			out_q.empty_error        <= e_q;
			out_q.full_error         <= f_q;
			out_q.zero_divisor_error <= z_q;
			out_q.unknown_error      <= (cur_q.kind == rse_pkg::K_UNKNOWN);
			out_q.saturated          <= sat_q;
			out_q.depth_now          <= 8'(cnt_q);
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;
endmodule
`default_nettype wire

FILE: rtl/core/rpn_stack_evaluator.sv
// sequencing: an unknown code goes straight to done; push writes the stack; print or a zero divisor
// pops the right operand only; add, subtract, multiply and divide pop both, compute and push
// the back end works on one command at a time and takes the next only once its result is registered
// a four-entry command queue takes beats while the back end works; a stalled result holds the back end
// reset: asynchronous, empties the stack and queue; stack memory is not cleared
`default_nettype none
`include "rpn_stack_evaluator_macros.svh"
module rpn_stack_evaluator #(
	parameter int STACK_DEPTH = 128
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [2:0]          op,
	input  wire logic signed [31:0]  operand_value,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [31:0]       printed_value,
	output logic                     printed_valid,
	output logic                     empty_error,
	output logic                     full_error,
	output logic                     zero_divisor_error,
	output logic                     unknown_error,
	output logic                     saturated,
	output logic [7:0]               depth_now
);
	logic          cmd_valid;
	logic          cmd_take;
	rse_pkg::cmd_t cmd;
	rse_pkg::res_t res;

	rse_front u_front (
		.clk, .arst_n,
		.valid(in_valid), .stall(in_stall),
		.op, .operand_value(operand_value),
		.cmd_valid, .cmd, .cmd_take
	);

	rse_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
		.clk, .arst_n,
		.cmd_valid, .cmd, .cmd_take,
		.res_valid(out_valid), .res, .res_stall(out_stall)
	);

	assign printed_value      = res.printed_value;
	assign printed_valid      = res.printed_valid;
	assign empty_error        = res.empty_error;
	assign full_error         = res.full_error;
	assign zero_divisor_error = res.zero_divisor_error;
	assign unknown_error      = res.unknown_error;
	assign saturated          = res.saturated;
	assign depth_now          = res.depth_now;

	`RSE_ASSERT_IMP(a_one_flag_kind, clk, arst_n, out_valid,
		!(printed_valid && unknown_error))
	`RSE_ASSERT_IMP(a_print_zero, clk, arst_n, out_valid && !printed_valid,
		printed_value == 32'sd0)
	`RSE_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(depth_now))
endmodule
`default_nettype wire
